@@ rtl/s2d_pkg.sv @@
package s2d_pkg;

  localparam int COORD_BYTES_DEF  = 32;
  localparam int DIGEST_BYTES_DEF = 32;
  localparam int MAX_RESULTS      = 34;
  localparam int ZCNT_W           = 6;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [7:0] TAG_SEQ    = 8'h30;
  localparam logic [7:0] TAG_INT    = 8'h02;
  localparam logic [7:0] TAG_OCT    = 8'h04;
  localparam logic [7:0] RAW_PREFIX = 8'h04;
  localparam logic [6:0] LEN_CNT_MAX = 7'd4;

  typedef enum logic [14:0] {
    PH_SEQ_TAG = 15'b000000000000001,
    PH_SEQ_LEN = 15'b000000000000010,
    PH_X_TAG   = 15'b000000000000100,
    PH_X_LEN   = 15'b000000000001000,
    PH_X_VAL   = 15'b000000000010000,
    PH_Y_TAG   = 15'b000000000100000,
    PH_Y_LEN   = 15'b000000001000000,
    PH_Y_VAL   = 15'b000000010000000,
    PH_D_TAG   = 15'b000000100000000,
    PH_D_LEN   = 15'b000001000000000,
    PH_D_VAL   = 15'b000010000000000,
    PH_B_TAG   = 15'b000100000000000,
    PH_B_LEN   = 15'b001000000000000,
    PH_B_VAL   = 15'b010000000000000,
    PH_DONE    = 15'b100000000000000
  } phase_e;

  // One command per accepted input word: the results that word causes.
  typedef struct packed {
    logic              byte_en;
    logic [7:0]        data;
    logic [ZCNT_W-1:0] zcnt;
    logic              dig_en;
    logic              stat_en;
    logic              stat_bad;
  } cmd_t;

endpackage

@@ rtl/s2d_front.sv @@
module s2d_front import s2d_pkg::*; #(
  parameter int COORD_BYTES  = COORD_BYTES_DEF,
  parameter int DIGEST_BYTES = DIGEST_BYTES_DEF,
  localparam int DigAw       = $clog2(DIGEST_BYTES)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       in_byte_i,
  input  logic             in_last_i,
  input  logic             fifo_full_i,
  output logic             push_o,
  output cmd_t             cmd_o,
  output logic             dig_we_o,
  output logic [DigAw-1:0] dig_waddr_o,
  output logic [7:0]       dig_wdata_o
);

  localparam int ZrMax = (COORD_BYTES > MAX_RESULTS) ? COORD_BYTES : MAX_RESULTS;
  localparam int ZrW   = $clog2(ZrMax + 1);
  localparam int CntW  = $clog2(COORD_BYTES + DIGEST_BYTES + MAX_RESULTS + 2);

  phase_e      phase_q, phase_d;
  logic [31:0] acc_q, acc_d;
  logic [2:0]  lleft_q, lleft_d;
  logic [31:0] vleft_q, vleft_d;
  logic [31:0] seqlen_q, seqlen_d;
  logic [31:0] bah_q, bah_d;
  logic        mal_q, mal_d;

  logic [31:0]    len_val;
  logic [ZrW-1:0] zraw;
  logic           zero_en;
  logic [CntW-1:0] cnt;
  logic [31:0]    widx;
  logic           ok;

  assign in_ready_o  = !fifo_full_i;
  assign push_o      = in_valid_i && in_ready_o;
  assign len_val     = (lleft_q == 3'd0) ? {24'd0, in_byte_i} : {acc_q[23:0], in_byte_i};
  assign zraw        = ZrW'(COORD_BYTES) - len_val[ZrW-1:0];
  assign widx        = 32'(DIGEST_BYTES) - vleft_q;
  assign dig_waddr_o = widx[DigAw-1:0];
  assign dig_wdata_o = in_byte_i;

  always_comb begin
    phase_d  = phase_q;
    acc_d    = acc_q;
    lleft_d  = lleft_q;
    vleft_d  = vleft_q;
    seqlen_d = seqlen_q;
    bah_d    = bah_q;
    mal_d    = mal_q;
    cmd_o    = '0;
    zero_en  = 1'b0;
    dig_we_o = 1'b0;
    if (!mal_q) begin
      if (phase_q != PH_SEQ_TAG && phase_q != PH_SEQ_LEN && bah_q != '1) begin
        bah_d = bah_q + 32'd1;
      end
      unique case (phase_q)
        PH_SEQ_TAG: begin
          if (in_byte_i != TAG_SEQ) begin
            mal_d = 1'b1;
          end else begin
            cmd_o.byte_en = 1'b1;
            cmd_o.data    = RAW_PREFIX;
            phase_d       = PH_SEQ_LEN;
          end
        end
        PH_X_TAG, PH_Y_TAG: begin
          if (in_byte_i != TAG_INT) begin
            mal_d = 1'b1;
          end else begin
            phase_d = (phase_q == PH_X_TAG) ? PH_X_LEN : PH_Y_LEN;
          end
        end
        PH_D_TAG, PH_B_TAG: begin
          if (in_byte_i != TAG_OCT) begin
            mal_d = 1'b1;
          end else begin
            phase_d = (phase_q == PH_D_TAG) ? PH_D_LEN : PH_B_LEN;
          end
        end
        PH_SEQ_LEN, PH_X_LEN, PH_Y_LEN, PH_D_LEN, PH_B_LEN: begin
          if (lleft_q == 3'd0 && in_byte_i[7]) begin
            if (in_byte_i[6:0] == 7'd0 || in_byte_i[6:0] > LEN_CNT_MAX) begin
              mal_d = 1'b1;
            end else begin
              lleft_d = in_byte_i[2:0];
              acc_d   = '0;
            end
          end else begin
            if (lleft_q != 3'd0) begin
              acc_d   = len_val;
              lleft_d = lleft_q - 3'd1;
            end
            if (lleft_q <= 3'd1) begin
              if (phase_q == PH_SEQ_LEN) begin
                seqlen_d = len_val;
                phase_d  = PH_X_TAG;
              end else if (phase_q == PH_X_LEN || phase_q == PH_Y_LEN) begin
                zero_en = (len_val < 32'(COORD_BYTES));
                vleft_d = len_val;
                if (len_val == 32'd0) begin
                  phase_d = (phase_q == PH_X_LEN) ? PH_Y_TAG : PH_D_TAG;
                end else begin
                  phase_d = (phase_q == PH_X_LEN) ? PH_X_VAL : PH_Y_VAL;
                end
              end else if (phase_q == PH_D_LEN) begin
                if (len_val != 32'(DIGEST_BYTES)) begin
                  mal_d = 1'b1;
                end else begin
                  vleft_d = len_val;
                  phase_d = PH_D_VAL;
                end
              end else begin
                if (len_val == 32'd0) begin
                  mal_d = 1'b1;
                end else begin
                  vleft_d = len_val;
                  phase_d = PH_B_VAL;
                end
              end
            end
          end
        end
        PH_X_VAL, PH_Y_VAL: begin
          if (vleft_q > 32'(COORD_BYTES) && in_byte_i != 8'd0) begin
            mal_d = 1'b1;
          end else begin
            if (vleft_q <= 32'(COORD_BYTES)) begin
              cmd_o.byte_en = 1'b1;
              cmd_o.data    = in_byte_i;
            end
            vleft_d = vleft_q - 32'd1;
            if (vleft_q == 32'd1) begin
              phase_d = (phase_q == PH_X_VAL) ? PH_Y_TAG : PH_D_TAG;
            end
          end
        end
        PH_D_VAL: begin
          dig_we_o = push_o;
          vleft_d  = vleft_q - 32'd1;
          if (vleft_q == 32'd1) begin
            phase_d = PH_B_TAG;
          end
        end
        PH_B_VAL: begin
          cmd_o.byte_en = 1'b1;
          cmd_o.data    = in_byte_i;
          vleft_d       = vleft_q - 32'd1;
          if (vleft_q == 32'd1) begin
            cmd_o.dig_en = 1'b1;
            phase_d      = PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end

    if (zero_en) begin
      cmd_o.zcnt = (zraw > ZrW'(MAX_RESULTS)) ? ZCNT_W'(MAX_RESULTS) : ZCNT_W'(zraw);
    end
    cnt = CntW'(cmd_o.byte_en) + (zero_en ? CntW'(zraw) : CntW'(0)) +
          (cmd_o.dig_en ? CntW'(DIGEST_BYTES) : CntW'(0));
    ok  = !mal_d && phase_d == PH_DONE && bah_d >= seqlen_d;

    if (in_last_i) begin
      cmd_o.stat_en  = (cnt < CntW'(MAX_RESULTS));
      cmd_o.stat_bad = !ok;
      phase_d  = PH_SEQ_TAG;
      acc_d    = '0;
      lleft_d  = '0;
      vleft_d  = '0;
      seqlen_d = '0;
      bah_d    = '0;
      mal_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SEQ_TAG;
      acc_q    <= '0;
      lleft_q  <= '0;
      vleft_q  <= '0;
      seqlen_q <= '0;
      bah_q    <= '0;
      mal_q    <= 1'b0;
    end else if (push_o) begin
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      lleft_q  <= lleft_d;
      vleft_q  <= vleft_d;
      seqlen_q <= seqlen_d;
      bah_q    <= bah_d;
      mal_q    <= mal_d;
    end
  end

endmodule

@@ rtl/s2d_fifo.sv @@
module s2d_fifo import s2d_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  localparam int Aw = $clog2(QUEUE_DEPTH);

  cmd_t        mem_q [QUEUE_DEPTH];
  logic [Aw-1:0] wptr_q, rptr_q;
  logic [Aw:0]   cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == (Aw+1)'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == Aw'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + Aw'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == Aw'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + Aw'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (Aw+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (Aw+1)'(1);
      end
    end
  end

endmodule

@@ rtl/s2d_back.sv @@
module s2d_back import s2d_pkg::*; #(
  parameter int DIGEST_BYTES = DIGEST_BYTES_DEF,
  localparam int DigAw       = $clog2(DIGEST_BYTES)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fifo_valid_i,
  input  cmd_t             fifo_cmd_i,
  output logic             pop_o,
  input  logic             dig_we_i,
  input  logic [DigAw-1:0] dig_waddr_i,
  input  logic [7:0]       dig_wdata_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             is_status_o,
  output logic             status_o
);

  localparam int DigCnt = (DIGEST_BYTES < MAX_RESULTS - 1) ? DIGEST_BYTES : MAX_RESULTS - 1;

  logic [7:0]       mem_q [DIGEST_BYTES];
  logic [7:0]       dig_q;
  cmd_t             work_q, work_d;
  logic [DigAw-1:0] idx_q, idx_d;
  logic             ov_q, ov_d;
  logic [7:0]       ob_q, ob_d;
  logic             os_q, os_d;
  logic             st_q, st_d;
  logic             slot;

  assign out_valid_o = ov_q;
  assign out_byte_o  = ob_q;
  assign is_status_o = os_q;
  assign status_o    = st_q;
  assign slot        = !ov_q || out_ready_i;

  always_comb begin
    work_d = work_q;
    idx_d  = idx_q;
    ov_d   = ov_q && !out_ready_i;
    ob_d   = ob_q;
    os_d   = os_q;
    st_d   = st_q;
    if (slot) begin
      priority if (work_q.byte_en) begin
        ov_d           = 1'b1;
        ob_d           = work_q.data;
        os_d           = 1'b0;
        st_d           = 1'b0;
        work_d.byte_en = 1'b0;
      end else if (work_q.zcnt != '0) begin
        ov_d        = 1'b1;
        ob_d        = 8'd0;
        os_d        = 1'b0;
        st_d        = 1'b0;
        work_d.zcnt = work_q.zcnt - ZCNT_W'(1);
      end else if (work_q.dig_en) begin
        ov_d = 1'b1;
        ob_d = dig_q;
        os_d = 1'b0;
        st_d = 1'b0;
        if (idx_q == DigAw'(DigCnt - 1)) begin
          work_d.dig_en = 1'b0;
          idx_d         = '0;
        end else begin
          idx_d = idx_q + DigAw'(1);
        end
      end else if (work_q.stat_en) begin
        ov_d           = 1'b1;
        ob_d           = 8'd0;
        os_d           = 1'b1;
        st_d           = work_q.stat_bad;
        work_d.stat_en = 1'b0;
      end
    end
    pop_o = fifo_valid_i && !(work_d.byte_en || work_d.zcnt != '0 || work_d.dig_en ||
                              work_d.stat_en);
    if (pop_o) begin
      work_d = fifo_cmd_i;
    end
  end

  // Read data always reflects the entry at the current digest index.
  always_ff @(posedge clk_i) begin
    if (dig_we_i) begin
      mem_q[dig_waddr_i] <= dig_wdata_i;
    end
    dig_q <= mem_q[idx_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q <= '0;
      idx_q  <= '0;
      ov_q   <= 1'b0;
      ob_q   <= '0;
      os_q   <= 1'b0;
      st_q   <= 1'b0;
    end else begin
      work_q <= work_d;
      idx_q  <= idx_d;
      ov_q   <= ov_d;
      ob_q   <= ob_d;
      os_q   <= os_d;
      st_q   <= st_d;
    end
  end

endmodule

@@ rtl/sm2_der_to_raw_ciphertext.sv @@
// Converts a DER-encoded SM2 ciphertext, fed one word (byte) per handshake, into the raw
// form 0x04 || x || y || body || digest, followed by one status word when a word marked
// last arrives. The parser takes one input word per cycle while the queue has room, and
// writes one command per word into a two-entry queue; the output sequencer delivers one
// word per cycle from that queue while the consumer is ready. A coordinate shorter than
// COORD_BYTES gets one zero byte prepended per missing byte, and the final body byte is
// followed by a replay of the buffered digest; the input stalls while the queue is full.
// Results pass through the queue and the work register before reaching the output. After
// a malformed status the consumer must discard the data words of that object.
module sm2_der_to_raw_ciphertext import s2d_pkg::*; #(
  parameter int COORD_BYTES  = COORD_BYTES_DEF,
  parameter int DIGEST_BYTES = DIGEST_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       is_status_o,
  output logic       status_o
);

  localparam int DigAw = $clog2(DIGEST_BYTES);

  cmd_t             push_cmd, head_cmd;
  logic             push, pop, full, head_valid;
  logic             dig_we;
  logic [DigAw-1:0] dig_waddr;
  logic [7:0]       dig_wdata;

  s2d_front #(
    .COORD_BYTES (COORD_BYTES),
    .DIGEST_BYTES(DIGEST_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .fifo_full_i(full),
    .push_o     (push),
    .cmd_o      (push_cmd),
    .dig_we_o   (dig_we),
    .dig_waddr_o(dig_waddr),
    .dig_wdata_o(dig_wdata)
  );

  s2d_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(head_valid),
    .cmd_o  (head_cmd)
  );

  s2d_back #(
    .DIGEST_BYTES(DIGEST_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_valid_i(head_valid),
    .fifo_cmd_i  (head_cmd),
    .pop_o       (pop),
    .dig_we_i    (dig_we),
    .dig_waddr_i (dig_waddr),
    .dig_wdata_i (dig_wdata),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .is_status_o (is_status_o),
    .status_o    (status_o)
  );

endmodule

@@ rtl/s2d_checker.sv @@
module s2d_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] in_byte_i,
  input logic       in_last_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       is_status_o,
  input logic       status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) &&
    $stable(is_status_o) && $stable(status_o))
    else $error("output word changed while stalled");

  a_status_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_status_o |-> out_byte_o == 8'd0)
    else $error("status word carries a nonzero byte");

  a_data_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_status_o |-> !status_o)
    else $error("data word carries a status flag");

  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind sm2_der_to_raw_ciphertext s2d_checker u_s2d_checker (.*);

@@ sim/tb_sm2_der_to_raw_ciphertext.sv @@
`timescale 1ns / 100ps

module tb_sm2_der_to_raw_ciphertext import s2d_pkg::*;;

  localparam int COORD  = COORD_BYTES_DEF;
  localparam int DIGEST = DIGEST_BYTES_DEF;
  localparam int RAND_WORDS  = 380;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 3000;

  localparam logic STAT_OK  = 1'b0;
  localparam logic STAT_BAD = 1'b1;
  localparam logic [1:0] BY_MODEL = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic       is_st;
    logic       st;
  } raw_word_t;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic [1:0] n_typed;
    raw_word_t  e0;
    raw_word_t  e1;
  } der_row_t;

  localparam raw_word_t RES_NONE   = '0;
  localparam raw_word_t RES_PREFIX = {RAW_PREFIX, 1'b0, STAT_OK};
  localparam raw_word_t RES_BAD    = {8'h00, 1'b1, STAT_BAD};

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] in_byte_i;
  logic       in_last_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] out_byte_o;
  logic       is_status_o;
  logic       status_o;

  sm2_der_to_raw_ciphertext uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .is_status_o (is_status_o),
    .status_o    (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Parser state of the predictor.
  phase_e      der_phase;
  logic [31:0] len_acc;
  logic [2:0]  len_left;
  logic [31:0] val_left;
  logic [31:0] seq_len;
  logic [31:0] hdr_count;
  logic [7:0]  digest_mem [DIGEST];
  logic        obj_bad;

  raw_word_t  step_words [$];
  raw_word_t  raw_words_q [$];
  der_row_t   dir_rows [$];
  logic [7:0] obj [$];
  logic [7:0] cont [$];

  int  n_errors = 0;
  int  n_counted = 0;
  int  quiet_cycles = 0;
  int  hold_left = 0;
  bit  hold_req = 1'b0;
  bit  hold_taken = 1'b0;
  bit  steady = 1'b0;
  raw_word_t want;

  task automatic note_mismatch(input string what, input logic [7:0] got,
                               input logic [7:0] exp_val);
    $display("ERROR at %0t: %s is %0h, expected %0h", $time, what, got, exp_val);
    n_errors++;
  endtask

  task automatic emit(input logic [7:0] b);
    if (step_words.size() < MAX_RESULTS) step_words.push_back({b, 1'b0, STAT_OK});
  endtask

  task automatic clear_parser();
    der_phase = PH_SEQ_TAG;
    len_acc   = '0;
    len_left  = '0;
    val_left  = '0;
    seq_len   = '0;
    hdr_count = '0;
    obj_bad   = 1'b0;
  endtask

  task automatic length_complete(input logic [31:0] len);
    case (der_phase)
      PH_SEQ_LEN: begin
        seq_len   = len;
        der_phase = PH_X_TAG;
      end
      PH_X_LEN, PH_Y_LEN: begin
        if (len < COORD) repeat (COORD - int'(len)) emit(8'h00);
        val_left = len;
        if (len == 0) der_phase = (der_phase == PH_X_LEN) ? PH_Y_TAG : PH_D_TAG;
        else der_phase = (der_phase == PH_X_LEN) ? PH_X_VAL : PH_Y_VAL;
      end
      PH_D_LEN: begin
        if (len != DIGEST) begin
          obj_bad = 1'b1;
        end else begin
          val_left  = len;
          der_phase = PH_D_VAL;
        end
      end
      default: begin
        if (len == 0) begin
          obj_bad = 1'b1;
        end else begin
          val_left  = len;
          der_phase = PH_B_VAL;
        end
      end
    endcase
  endtask

  task automatic parse_byte(input logic [7:0] b);
    logic [6:0] cnt;
    cnt = b[6:0];
    case (der_phase)
      PH_SEQ_TAG: begin
        if (b != TAG_SEQ) begin
          obj_bad = 1'b1;
        end else begin
          emit(RAW_PREFIX);
          der_phase = PH_SEQ_LEN;
        end
      end
      PH_X_TAG, PH_Y_TAG: begin
        if (b != TAG_INT) obj_bad = 1'b1;
        else der_phase = (der_phase == PH_X_TAG) ? PH_X_LEN : PH_Y_LEN;
      end
      PH_D_TAG, PH_B_TAG: begin
        if (b != TAG_OCT) obj_bad = 1'b1;
        else der_phase = (der_phase == PH_D_TAG) ? PH_D_LEN : PH_B_LEN;
      end
      PH_SEQ_LEN, PH_X_LEN, PH_Y_LEN, PH_D_LEN, PH_B_LEN: begin
        if (len_left == 0) begin
          if (!b[7]) begin
            length_complete({24'h0, b});
          end else if (cnt == 0 || cnt > LEN_CNT_MAX) begin
            obj_bad = 1'b1;
          end else begin
            len_left = cnt[2:0];
            len_acc  = '0;
          end
        end else begin
          len_acc  = {len_acc[23:0], b};
          len_left = len_left - 3'd1;
          if (len_left == 0) length_complete(len_acc);
        end
      end
      PH_X_VAL, PH_Y_VAL: begin
        if (val_left > COORD && b != 8'h00) begin
          obj_bad = 1'b1;
        end else begin
          if (val_left <= COORD) emit(b);
          val_left = val_left - 1;
          if (val_left == 0) der_phase = (der_phase == PH_X_VAL) ? PH_Y_TAG : PH_D_TAG;
        end
      end
      PH_D_VAL: begin
        if (DIGEST - val_left < DIGEST) digest_mem[DIGEST - val_left] = b;
        val_left = val_left - 1;
        if (val_left == 0) der_phase = PH_B_TAG;
      end
      PH_B_VAL: begin
        emit(b);
        val_left = val_left - 1;
        if (val_left == 0) begin
          for (int i = 0; i < DIGEST; i++) emit(digest_mem[i]);
          der_phase = PH_DONE;
        end
      end
      default: begin
      end
    endcase
  endtask

  // Works out the raw words caused by one DER word and leaves them in step_words.
  task automatic repack_word(input logic [7:0] b, input logic l);
    logic ok;
    step_words.delete();
    if (l || !(obj_bad || der_phase == PH_DONE)) n_counted++;
    if (!obj_bad) begin
      if (der_phase != PH_SEQ_TAG && der_phase != PH_SEQ_LEN && hdr_count != '1)
        hdr_count = hdr_count + 1;
      parse_byte(b);
    end
    if (l) begin
      ok = !obj_bad && der_phase == PH_DONE && hdr_count >= seq_len;
      if (step_words.size() < MAX_RESULTS)
        step_words.push_back({8'h00, 1'b1, ok ? STAT_OK : STAT_BAD});
      clear_parser();
    end
  endtask

  task automatic send_word(input logic [7:0] b, input logic l, input logic [1:0] n_typed,
                           input raw_word_t e0, input raw_word_t e1);
    bit done;
    done = 1'b0;
    while (!steady && $urandom_range(99) < 27) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    in_last_i  <= l;
    while (!done) begin
      @(negedge clk_i);
      if (in_ready_o) begin
        done = 1'b1;
        repack_word(b, l);
        if (n_typed == BY_MODEL) begin
          foreach (step_words[i]) raw_words_q.push_back(step_words[i]);
        end else begin
          if (n_typed > 0) raw_words_q.push_back(e0);
          if (n_typed > 1) raw_words_q.push_back(e1);
        end
      end
      @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (raw_words_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic add_row(input logic [7:0] b, input logic l, input logic [1:0] n,
                         input raw_word_t e0, input raw_word_t e1);
    dir_rows.push_back({b, l, n, e0, e1});
  endtask

  task automatic push_random(input int n);
    logic [7:0] rb;
    repeat (n) begin
      rb = 8'($urandom);
      cont.push_back(rb);
    end
  endtask

  task automatic put_len(input int unsigned len);
    int nb;
    logic [31:0] sh;
    if (len < 128 && $urandom_range(99) < 70) begin
      cont.push_back(len[7:0]);
    end else begin
      nb = $urandom_range(4, len < 256 ? 1 : 2);
      cont.push_back(8'h80 | nb[7:0]);
      for (int i = nb - 1; i >= 0; i--) begin
        sh = len >> (8 * i);
        cont.push_back(sh[7:0]);
      end
    end
  endtask

  task automatic add_int(input bit lead_bad);
    int n;
    int base;
    logic [7:0] rb;
    if ($urandom_range(99) < 45) n = COORD;
    else if ($urandom_range(99) < 70) n = $urandom_range(COORD - 1, 0);
    else n = $urandom_range(COORD + 2, COORD + 1);
    if (lead_bad) n = $urandom_range(COORD + 3, COORD + 1);
    cont.push_back(TAG_INT);
    put_len(n);
    base = cont.size();
    for (int i = 0; i < n; i++) begin
      rb = (i < n - COORD) ? 8'h00 : 8'($urandom);
      cont.push_back(rb);
    end
    if (lead_bad) cont[base + $urandom_range(n - COORD - 1, 0)] = 8'($urandom_range(255, 1));
  endtask

  task automatic build_object();
    int unsigned r, dl, bl, seql, split, cut, pos;
    logic [7:0] rb;
    r = $urandom_range(99);
    obj.delete();
    cont.delete();
    if (r >= 97) begin
      push_random($urandom_range(6, 1));
      foreach (cont[i]) obj.push_back(cont[i]);
    end else if (r >= 93) begin
      obj.push_back(TAG_SEQ);
      rb = $urandom_range(1) ? 8'h80 : (8'h80 | 8'($urandom_range(127, 5)));
      obj.push_back(rb);
      push_random($urandom_range(3, 0));
      foreach (cont[i]) obj.push_back(cont[i]);
    end else begin
      add_int(r >= 89);
      add_int(1'b0);
      dl = DIGEST;
      if (r >= 80 && r < 85) begin
        case ($urandom_range(2))
          0: dl = DIGEST - 1;
          1: dl = DIGEST + 1;
          default: dl = $urandom_range(60, 0);
        endcase
      end
      cont.push_back(TAG_OCT);
      put_len(dl);
      push_random(dl);
      bl = ($urandom_range(19) == 0) ? $urandom_range(140, 100) : $urandom_range(12, 1);
      if (r >= 85 && r < 89) bl = 0;
      cont.push_back(TAG_OCT);
      put_len(bl);
      push_random(bl);
      split = cont.size();
      seql = split;
      case ($urandom_range(9))
        0: seql = split - $urandom_range(5, 1);
        1: seql = split + $urandom_range(3, 1);
        default: ;
      endcase
      put_len(seql);
      obj.push_back(TAG_SEQ);
      for (int i = split; i < cont.size(); i++) obj.push_back(cont[i]);
      for (int i = 0; i < split; i++) obj.push_back(cont[i]);
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(3, 1)) begin
          rb = 8'($urandom);
          obj.push_back(rb);
        end
      end
      if (r >= 62 && r < 72) begin
        cut = $urandom_range(obj.size() - 1, 1);
        while (obj.size() > cut) void'(obj.pop_back());
      end
      if (r >= 72 && r < 80) begin
        pos = $urandom_range(obj.size() - 1, 0);
        rb = 8'($urandom_range(255, 1));
        obj[pos] = obj[pos] ^ rb;
      end
    end
  endtask

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= steady || ($urandom_range(99) >= 27);
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (raw_words_q.size() == 0) begin
          note_mismatch("unexpected word, out_byte", out_byte_o, 8'h00);
        end else begin
          want = raw_words_q.pop_front();
          if (out_byte_o !== want.data) note_mismatch("out_byte", out_byte_o, want.data);
          if (is_status_o !== want.is_st)
            note_mismatch("is_status", {7'h0, is_status_o}, {7'h0, want.is_st});
          if (status_o !== want.st)
            note_mismatch("status", {7'h0, status_o}, {7'h0, want.st});
        end
      end
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("ERROR: no word moved for %0d cycles", QUIET_LIMIT);
          $display("** sm2_der_to_raw_ciphertext: FAILED **");
          $finish;
        end
      end
    end
  end

  initial begin
    int obj_no;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_byte_i  = 8'h00;
    in_last_i  = 1'b0;
    clear_parser();

    add_row(8'h00,    1'b1, 2'd1, RES_BAD,    RES_NONE);
    add_row(8'hFF,    1'b1, 2'd1, RES_BAD,    RES_NONE);
    add_row(TAG_SEQ,  1'b1, 2'd2, RES_PREFIX, RES_BAD);
    add_row(TAG_SEQ,  1'b0, 2'd1, RES_PREFIX, RES_NONE);
    add_row(8'h80,    1'b0, 2'd0, RES_NONE,   RES_NONE);
    add_row(TAG_SEQ,  1'b1, 2'd1, RES_BAD,    RES_NONE);
    add_row(TAG_SEQ,  1'b0, 2'd1, RES_PREFIX, RES_NONE);
    add_row(8'h85,    1'b0, 2'd0, RES_NONE,   RES_NONE);
    add_row(8'h7F,    1'b1, 2'd1, RES_BAD,    RES_NONE);
    add_row(TAG_SEQ,  1'b0, 2'd1, RES_PREFIX, RES_NONE);
    add_row(8'h84,    1'b0, 2'd0, RES_NONE,   RES_NONE);
    add_row(8'hFF,    1'b0, 2'd0, RES_NONE,   RES_NONE);
    add_row(8'hFF,    1'b0, 2'd0, RES_NONE,   RES_NONE);
    add_row(8'hFF,    1'b0, 2'd0, RES_NONE,   RES_NONE);
    add_row(8'hFF,    1'b0, 2'd0, RES_NONE,   RES_NONE);
    add_row(TAG_INT,  1'b0, 2'd0, RES_NONE,   RES_NONE);
    add_row(8'h00,    1'b0, BY_MODEL, RES_NONE, RES_NONE);
    add_row(TAG_INT,  1'b0, 2'd0, RES_NONE,   RES_NONE);
    add_row(8'h22,    1'b0, 2'd0, RES_NONE,   RES_NONE);
    add_row(8'h00,    1'b0, 2'd0, RES_NONE,   RES_NONE);
    add_row(8'h01,    1'b0, 2'd0, RES_NONE,   RES_NONE);
    add_row(8'h55,    1'b1, 2'd1, RES_BAD,    RES_NONE);
    add_row(TAG_SEQ,  1'b0, 2'd1, RES_PREFIX, RES_NONE);
    add_row(8'h7F,    1'b0, 2'd0, RES_NONE,   RES_NONE);
    add_row(TAG_OCT,  1'b1, 2'd1, RES_BAD,    RES_NONE);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_word(dir_rows[i].b, dir_rows[i].last, dir_rows[i].n_typed,
                dir_rows[i].e0, dir_rows[i].e1);
    wait_drained();

    // The sink stalls for a long stretch while the first objects keep coming.
    hold_req  = 1'b1;
    n_counted = 0;
    obj_no    = 0;
    while (n_counted < RAND_WORDS) begin
      steady = (obj_no == 3 || obj_no == 4);
      build_object();
      foreach (obj[i]) send_word(obj[i], i == obj.size() - 1, BY_MODEL, RES_NONE, RES_NONE);
      if (obj_no == 2) wait_drained();
      obj_no++;
    end
    steady = 1'b0;
    wait_drained();
    repeat (10) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("** sm2_der_to_raw_ciphertext: PASSED **");
    end else begin
      $display("** sm2_der_to_raw_ciphertext: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/s2d_pkg.sv
rtl/s2d_front.sv
rtl/s2d_fifo.sv
rtl/s2d_back.sv
rtl/sm2_der_to_raw_ciphertext.sv
rtl/s2d_checker.sv
sim/tb_sm2_der_to_raw_ciphertext.sv
